// ===== rtl/atd_pkg.sv =====
`default_nettype none
package atd_pkg;

  localparam int COEF_SETS   = 32;
  localparam int FRAME_BYTES = 18;
  localparam int TAPS        = 3;
  localparam int TABLE_SIZE  = COEF_SETS * TAPS;
  localparam int HDR_BYTES   = 2;

  localparam int COEF_W   = 16;
  localparam int ADDR_W   = $clog2(TABLE_SIZE);
  localparam int SET_W    = $clog2(COEF_SETS);
  localparam int POS_W    = 5;
  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 23;
  localparam int MUL_A_W  = 16;
  localparam int MUL_B_W  = SCALE_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 36;
  localparam int SHIFT    = 12;
  localparam int SAT_TOP  = SHIFT + SAMPLE_W - 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MULS,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_NEG,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  function automatic logic [SCALE_W-1:0] scale_rom(input logic [4:0] idx);
    logic [SCALE_W-1:0] s;
    case (idx)
      5'd0:  s = 23'h001000;
      5'd1:  s = 23'h00144E;
      5'd2:  s = 23'h0019C5;
      5'd3:  s = 23'h0020B4;
      5'd4:  s = 23'h002981;
      5'd5:  s = 23'h0034AC;
      5'd6:  s = 23'h0042D9;
      5'd7:  s = 23'h0054D6;
      5'd8:  s = 23'h006BAB;
      5'd9:  s = 23'h0088A4;
      5'd10: s = 23'h00AD69;
      5'd11: s = 23'h00DC13;
      5'd12: s = 23'h01174C;
      5'd13: s = 23'h016275;
      5'd14: s = 23'h01C1D8;
      5'd15: s = 23'h023AE5;
      5'd16: s = 23'h02D486;
      5'd17: s = 23'h03977E;
      5'd18: s = 23'h048EEE;
      5'd19: s = 23'h05C8F3;
      5'd20: s = 23'h075779;
      5'd21: s = 23'h09513E;
      5'd22: s = 23'h0BD31C;
      5'd23: s = 23'h0F01B5;
      5'd24: s = 23'h130B82;
      5'd25: s = 23'h182B83;
      5'd26: s = 23'h1EAC92;
      5'd27: s = 23'h26EDB2;
      5'd28: s = 23'h316777;
      5'd29: s = 23'h3EB2E6;
      5'd30: s = 23'h4F9232;
      5'd31: s = 23'h64FBD1;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/atd_ram.sv =====
`default_nettype none
module atd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/atd_mac.sv =====
`default_nettype none
module atd_mac (
  input  wire logic                                  clk,
  input  wire atd_pkg::mac_ctrl_t                    ctrl,
  input  wire logic signed [atd_pkg::MUL_A_W-1:0]    mul_a,
  input  wire logic signed [atd_pkg::MUL_B_W-1:0]    mul_b,
  output logic signed [atd_pkg::SAMPLE_W-1:0]        sample
);

  logic signed [atd_pkg::PROD_W-1:0] prod;
  logic signed [atd_pkg::ACC_W-1:0]  prod_t;
  logic signed [atd_pkg::ACC_W-1:0]  acc;
  logic                              fits;

  // products stay well below 2^33, so the narrow accumulator is exact
  assign prod_t = prod[atd_pkg::ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (ctrl.acc_op)
      atd_pkg::ACC_LOAD_NEG: acc <= -prod_t;
      atd_pkg::ACC_SUB:      acc <= acc - prod_t;
      atd_pkg::ACC_ADD:      acc <= acc + prod_t;
      default:               acc <= acc;
    endcase
  end

  // floor shift by SHIFT is a plain bit select; saturate if upper bits disagree
  assign fits = (acc[atd_pkg::ACC_W-1:atd_pkg::SAT_TOP] == '0)
             || (acc[atd_pkg::ACC_W-1:atd_pkg::SAT_TOP] == '1);

  always_comb begin
    if (fits) begin
      sample = acc[atd_pkg::SAT_TOP:atd_pkg::SHIFT];
    end else if (acc[atd_pkg::ACC_W-1]) begin
      sample = {1'b1, {(atd_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sample = {1'b0, {(atd_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/adpcm_three_tap_decoder.sv =====
// channel  signals                                       item
// input    item_valid/item_ready, cmd, coef_addr,        one coefficient load or stream byte
//          coef_value, data_byte
// output   result_valid/result_ready, sample,            one decoded sample
//          last_of_byte
//
// Load and header items do not leave idle. A data byte runs each sample through the
// shared multiplier (three taps and the scale, one product a cycle, coefficients read
// from the table RAM in the state before). Synchronous reset clears frame position,
// header fields, history and the output valid flag; the coefficient table is not
// cleared. A result not taken holds the datapath in its output step; a new item is
// taken while the last result still waits.
`default_nettype none
module adpcm_three_tap_decoder (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_ready,
  input  wire logic                                  cmd,
  input  wire logic [6:0]                            coef_addr,
  input  wire logic signed [atd_pkg::COEF_W-1:0]     coef_value,
  input  wire logic [7:0]                            data_byte,
  output logic                                       result_valid,
  input  wire logic                                  result_ready,
  output logic signed [atd_pkg::SAMPLE_W-1:0]        sample,
  output logic                                       last_of_byte
);

  atd_pkg::state_t state, state_next;

  logic [atd_pkg::POS_W-1:0]  byte_position;
  logic [7:0]                 header_low_byte;
  logic [atd_pkg::SET_W-1:0]  coef_set;
  logic [4:0]                 pos_scale_index;
  logic [4:0]                 neg_scale_index;
  logic signed [atd_pkg::SAMPLE_W-1:0] history_one, history_two, history_three;
  logic [7:0]                 data_reg;
  logic                       nib_sel;

  logic                       accept;
  logic                       mem_we;
  logic [atd_pkg::ADDR_W-1:0] raddr;
  logic [atd_pkg::ADDR_W-1:0] base;
  logic [1:0]                 tap;
  logic signed [atd_pkg::COEF_W-1:0] rdata;
  logic [3:0]                 nib;
  logic [atd_pkg::SCALE_W-1:0] scale;
  logic signed [atd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [atd_pkg::MUL_B_W-1:0] mul_b;
  atd_pkg::mac_ctrl_t         ctrl;
  logic signed [atd_pkg::SAMPLE_W-1:0] mac_sample;
  logic                       out_load;

  assign accept = item_valid && item_ready;
  assign mem_we = accept && (cmd == atd_pkg::CMD_LOAD)
                  && (coef_addr < atd_pkg::ADDR_W'(atd_pkg::TABLE_SIZE));

  // set * 3 + tap
  assign base  = {1'b0, coef_set, 1'b0} + {2'b00, coef_set};
  assign raddr = base + {{(atd_pkg::ADDR_W-2){1'b0}}, tap};

  assign nib   = nib_sel ? data_reg[3:0] : data_reg[7:4];
  assign scale = atd_pkg::scale_rom(nib[3] ? neg_scale_index : pos_scale_index);

  atd_ram #(
    .WIDTH (atd_pkg::COEF_W),
    .DEPTH (atd_pkg::TABLE_SIZE)
  ) u_coef_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (coef_addr[atd_pkg::ADDR_W-1:0]),
    .wdata (coef_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  atd_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .sample (mac_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    item_ready  = 1'b0;
    out_load    = 1'b0;
    tap         = 2'd0;
    ctrl.mul_en = 1'b0;
    ctrl.acc_op = atd_pkg::ACC_HOLD;
    mul_a       = history_one;
    mul_b       = {{(atd_pkg::MUL_B_W-atd_pkg::COEF_W){rdata[atd_pkg::COEF_W-1]}}, rdata};
    case (state)
      atd_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        // tap 0 read issued here for a data byte
        if (item_valid && (cmd == atd_pkg::CMD_BYTE)
            && (byte_position >= atd_pkg::POS_W'(atd_pkg::HDR_BYTES))) begin
          state_next = atd_pkg::ST_MUL1;
        end
      end
      atd_pkg::ST_MUL1: begin
        ctrl.mul_en = 1'b1;
        mul_a       = history_one;
        tap         = 2'd1;
        state_next  = atd_pkg::ST_MUL2;
      end
      atd_pkg::ST_MUL2: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = atd_pkg::ACC_LOAD_NEG;
        mul_a       = history_two;
        tap         = 2'd2;
        state_next  = atd_pkg::ST_MUL3;
      end
      atd_pkg::ST_MUL3: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = atd_pkg::ACC_SUB;
        mul_a       = history_three;
        state_next  = atd_pkg::ST_MULS;
      end
      atd_pkg::ST_MULS: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = atd_pkg::ACC_SUB;
        mul_a       = {{(atd_pkg::MUL_A_W-4){nib[3]}}, nib};
        mul_b       = {1'b0, scale};
        state_next  = atd_pkg::ST_ACC;
      end
      atd_pkg::ST_ACC: begin
        ctrl.acc_op = atd_pkg::ACC_ADD;
        state_next  = atd_pkg::ST_OUT;
      end
      atd_pkg::ST_OUT: begin
        // tap 0 of the low nibble is read while waiting here
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = nib_sel ? atd_pkg::ST_IDLE : atd_pkg::ST_MUL1;
        end
      end
      default: begin
        state_next = atd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_low_byte <= '0;
      coef_set        <= '0;
      pos_scale_index <= '0;
      neg_scale_index <= '0;
      history_one     <= '0;
      history_two     <= '0;
      history_three   <= '0;
      nib_sel         <= 1'b0;
    end else begin
      if (accept && (cmd == atd_pkg::CMD_BYTE)) begin
        byte_position <= (byte_position == atd_pkg::POS_W'(atd_pkg::FRAME_BYTES - 1))
                         ? '0 : byte_position + 1'b1;
        if (byte_position == '0) begin
          header_low_byte <= data_byte;
        end else if (byte_position == atd_pkg::POS_W'(1)) begin
          coef_set        <= data_byte[6:2];
          pos_scale_index <= {data_byte[1:0], header_low_byte[7:5]};
          neg_scale_index <= header_low_byte[4:0];
        end
        nib_sel <= 1'b0;
      end
      if (out_load) begin
        history_three <= history_two;
        history_two   <= history_one;
        history_one   <= mac_sample;
        nib_sel       <= ~nib_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_reg <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample       <= mac_sample;
      last_of_byte <= nib_sel;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == atd_pkg::ST_IDLE))
    else $error("table write outside idle");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position < atd_pkg::POS_W'(atd_pkg::FRAME_BYTES))
    else $error("frame position out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!result_valid || result_ready))
    else $error("pending result overwritten");

  a_byte_done: assert property (@(posedge clk) disable iff (rst)
    (out_load && nib_sel) |=> (state == atd_pkg::ST_IDLE) && last_of_byte)
    else $error("low nibble did not end the byte");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [atd_pkg::SAMPLE_W-1:0] pcm;
    logic                                last_flag;
  } pcm_result_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_PERIODIC
  } ready_mode_t;

  localparam int ITEM_TARGET = 1400;

  // step sizes, indexed by the header's scale fields
  localparam longint SCALE_STEPS [32] = '{
    'h00001000, 'h0000144E, 'h000019C5, 'h000020B4, 'h00002981, 'h000034AC, 'h000042D9,
    'h000054D6, 'h00006BAB, 'h000088A4, 'h0000AD69, 'h0000DC13, 'h0001174C, 'h00016275,
    'h0001C1D8, 'h00023AE5, 'h0002D486, 'h0003977E, 'h00048EEE, 'h0005C8F3, 'h00075779,
    'h0009513E, 'h000BD31C, 'h000F01B5, 'h00130B82, 'h00182B83, 'h001EAC92, 'h0026EDB2,
    'h00316777, 'h003EB2E6, 'h004F9232, 'h0064FBD1
  };

  class sample_scoreboard;
    int                                 frame_pos;
    logic [7:0]                         hdr_lo;
    logic [4:0]                         set_sel;
    logic [4:0]                         pos_idx;
    logic [4:0]                         neg_idx;
    logic signed [15:0]                 hist [atd_pkg::TAPS];
    logic signed [atd_pkg::COEF_W-1:0]  coef [atd_pkg::TABLE_SIZE];
    pcm_result_t                        expected_q [$];
    int                                 mismatches;

    function new();
      frame_pos = 0;
      hdr_lo = '0;
      set_sel = '0;
      pos_idx = '0;
      neg_idx = '0;
      foreach (hist[i]) hist[i] = '0;
      foreach (coef[i]) coef[i] = '0;
      mismatches = 0;
    endfunction

    function logic signed [15:0] decode_nibble(logic [3:0] nib);
      longint             n;
      longint             pred;
      longint             step;
      longint             acc;
      int                 base;
      logic signed [15:0] r;
      n = longint'($signed(nib));
      base = set_sel * atd_pkg::TAPS;
      pred = 0;
      for (int t = 0; t < atd_pkg::TAPS; t++)
        pred -= longint'(hist[t]) * longint'(coef[base + t]);
      step = (n >= 0) ? SCALE_STEPS[pos_idx] : SCALE_STEPS[neg_idx];
      acc = (pred + n * step) >>> atd_pkg::SHIFT;
      if (acc > 32767) r = 16'sh7FFF;
      else if (acc < -32768) r = 16'sh8000;
      else r = 16'(acc);
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = r;
      return r;
    endfunction

    function void note_input(logic c, logic [6:0] addr, logic [15:0] val, logic [7:0] b);
      int          p;
      logic [15:0] hdr;
      pcm_result_t e;
      if (c == atd_pkg::CMD_LOAD) begin
        if (addr < atd_pkg::TABLE_SIZE) coef[addr] = val;
        return;
      end
      p = frame_pos;
      frame_pos = (p + 1 >= atd_pkg::FRAME_BYTES) ? 0 : p + 1;
      if (p == 0) begin
        hdr_lo = b;
      end else if (p == 1) begin
        hdr = {b, hdr_lo};
        set_sel = hdr[14:10];
        pos_idx = hdr[9:5];
        neg_idx = hdr[4:0];
      end else begin
        e.pcm = decode_nibble(b[7:4]);
        e.last_flag = 1'b0;
        expected_q.push_back(e);
        e.pcm = decode_nibble(b[3:0]);
        e.last_flag = 1'b1;
        expected_q.push_back(e);
      end
    endfunction

    function void check_result(logic signed [15:0] s, logic l);
      pcm_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result sample %0d last_of_byte %b", $time, s, l);
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.pcm || l !== e.last_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch sample exp %0d got %0d, last_of_byte exp %b got %b",
                   $time, e.pcm, s, e.last_flag, l);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                item_valid = 1'b0;
  logic                                item_ready;
  logic                                cmd = atd_pkg::CMD_LOAD;
  logic [6:0]                          coef_addr = '0;
  logic signed [atd_pkg::COEF_W-1:0]   coef_value = '0;
  logic [7:0]                          data_byte = '0;
  logic                                result_valid;
  logic                                result_ready = 1'b0;
  logic signed [atd_pkg::SAMPLE_W-1:0] sample;
  logic                                last_of_byte;

  sample_scoreboard decoder = new();

  // stimulus bookkeeping
  int                           items_done = 0;
  int                           burst_left = 0;
  int                           gen_pos = 0;
  logic [7:0]                   hdr_hi_pending = '0;
  bit [atd_pkg::TABLE_SIZE-1:0] loaded_mask = '0;

  // receiver pattern
  ready_mode_t           rdy_mode = RDY_ALWAYS;
  int                    mode_left = 0;
  int unsigned           tick = 0;

  adpcm_three_tap_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cmd          (cmd),
    .coef_addr    (coef_addr),
    .coef_value   (coef_value),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample       (sample),
    .last_of_byte (last_of_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) decoder.check_result(sample, last_of_byte);
      if (mode_left == 0) begin
        rdy_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      tick++;
      case (rdy_mode)
        RDY_ALWAYS: result_ready <= 1'b1;
        RDY_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
        RDY_RARELY: result_ready <= ($urandom_range(0, 3) == 0);
        default:    result_ready <= ((tick % 16) < 5);
      endcase
    end
  end

  function automatic bit set_loaded(int s);
    return &loaded_mask[s * atd_pkg::TAPS +: atd_pkg::TAPS];
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 12288) - 6144);
    endcase
  endfunction

  // bursts of items with random gaps; valid drops only at a burst boundary
  task automatic send_item(logic c, logic [6:0] addr, logic [15:0] val, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
    item_valid <= 1'b1;
    cmd <= c;
    coef_addr <= addr;
    coef_value <= val;
    data_byte <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    decoder.note_input(c, addr, val, b);
    if (c == atd_pkg::CMD_BYTE || addr < atd_pkg::TABLE_SIZE) items_done++;
  endtask

  task automatic send_load(logic [6:0] addr, logic [15:0] val);
    if (addr < atd_pkg::TABLE_SIZE) loaded_mask[addr] = 1'b1;
    send_item(atd_pkg::CMD_LOAD, addr, val, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    gen_pos = (gen_pos + 1 == atd_pkg::FRAME_BYTES) ? 0 : gen_pos + 1;
    send_item(atd_pkg::CMD_BYTE, 7'($urandom), 16'($urandom), b);
  endtask

  // next byte of a well-formed frame; headers only pick fully loaded sets
  task automatic stream_byte();
    logic [15:0] hdr;
    int          s;
    logic [4:0]  p;
    logic [4:0]  n;
    if (gen_pos == 0) begin
      do s = $urandom_range(0, atd_pkg::COEF_SETS - 1); while (!set_loaded(s));
      p = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 18));
      n = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 18));
      hdr = {1'($urandom), 5'(s), p, n};
      hdr_hi_pending = hdr[15:8];
      send_byte(hdr[7:0]);
    end else if (gen_pos == 1) begin
      send_byte(hdr_hi_pending);
    end else begin
      case ($urandom_range(0, 11))
        0:       send_byte(8'h00);
        1:       send_byte(8'hFF);
        2:       send_byte(8'h78);
        3:       send_byte(8'h87);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  initial begin
    int roll;
    int s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // out-of-range loads are dropped
    send_load(7'd96, 16'h1234);
    send_load(7'd127, 16'hFFFF);
    send_load(7'd0, 16'h0000);
    send_load(7'd1, 16'h0000);
    send_load(7'd2, 16'h0000);
    send_load(7'd93, 16'h7FFF);
    send_load(7'd94, 16'h8000);
    send_load(7'd95, 16'h7FFF);
    // header word with bit 15 set: set 31, both scales at the top of the table
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h18);
    // mid-frame load into the active set applies to the next sample
    send_load(7'd93, 16'h8000);
    send_byte(8'h7F);
    send_byte(8'h81);

    while (items_done < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (gen_pos == 0 && roll < 12) begin
        s = $urandom_range(0, atd_pkg::COEF_SETS - 1);
        for (int t = 0; t < atd_pkg::TAPS; t++)
          send_load(7'(s * atd_pkg::TAPS + t), pick_coef());
      end else if (roll >= 95) begin
        if ($urandom_range(0, 9) == 0) send_load(7'($urandom_range(96, 127)), pick_coef());
        else send_load(7'($urandom_range(0, atd_pkg::TABLE_SIZE - 1)), pick_coef());
      end else begin
        stream_byte();
      end
    end

    item_valid <= 1'b0;
    while (decoder.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (decoder.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
